// ===== design/swap_permutation_generator_unit_macros.svh =====
// Assertion macros shared by the permutation generator modules.
`ifndef SWAP_PERMUTATION_GENERATOR_UNIT_MACROS_SVH
`define SWAP_PERMUTATION_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPG_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("spg check failed");

// Next-cycle implication, checked outside reset.
`define SPG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("spg check failed");

`endif

// ===== design/spg_pkg.sv =====
// Package with the types and constants of the swap permutation generator.
package spg_pkg;

    localparam int DEF_MAX_LEN     = 8;
    localparam int DEF_SYMBOL_BITS = 8;
    localparam int SYMBOLS_W       = 64;
    localparam int LENGTH_W        = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int IN_DATA_W       = 8;

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UNDO,
        ST_REDO,
        ST_WRAP,
        ST_EMIT
    } spg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // reload the string and reset the level stack
        logic undo;     // undo the swap at the current level
        logic up;       // step one level up after an exhausted level
        logic redo;     // apply the next swap and descend below
        logic wrap;     // enumeration finished, descend from level zero
        logic capture;  // copy the working string into the output register
    } spg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic started;  // a string has been loaded since the last length write
        logic more;     // the current level has another swap partner
        logic top;      // the current level is level zero
        logic out_busy; // a result beat is held and not taken this cycle
    } spg_status_t;

endpackage

// ===== design/spg_datapath.sv =====
// Datapath: configuration, working string, level stack and output register.
`include "swap_permutation_generator_unit_macros.svh"

module spg_datapath #(
    parameter int MAX_LEN     = spg_pkg::DEF_MAX_LEN,
    parameter int SYMBOL_BITS = spg_pkg::DEF_SYMBOL_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [spg_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [spg_pkg::SYMBOLS_W-1:0]  cfg_wr_data,
    input  spg_pkg::spg_cmd_t              cmd,
    output spg_pkg::spg_status_t           status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spg_pkg::SYMBOLS_W-1:0]  m_tdata,
    output logic                           m_tlast
);
    import spg_pkg::*;

    localparam int LVL_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    logic [SYMBOLS_W-1:0]   symbols_reg;
    logic [LENGTH_W-1:0]    length_reg;
    logic                   started_reg, started_next;
    logic [SYMBOL_BITS-1:0] order_reg [MAX_LEN];
    logic [SYMBOL_BITS-1:0] order_next [MAX_LEN];
    logic [LVL_W-1:0]       lvl_idx_reg [MAX_LEN];
    logic [LVL_W-1:0]       lvl_idx_next [MAX_LEN];
    logic [LVL_W-1:0]       lv_reg, lv_next;
    logic [LVL_W-1:0]       nidx_reg, nidx_next;
    logic [SYMBOLS_W-1:0]   out_data_reg;
    logic                   out_last_reg;
    logic                   out_valid_reg, out_valid_next;

    logic [CNT_W-1:0]       n_eff;
    logic [LVL_W-1:0]       n_m1;
    logic [LVL_W-1:0]       cur_idx, clamp_idx, partner;
    logic [CNT_W-1:0]       idx_inc;
    logic [SYMBOL_BITS-1:0] sym_lv, sym_partner;
    logic [SYMBOLS_W-1:0]   packed_w;
    logic                   last_w;

    // Effective length: zero counts as one, large values saturate.
    always_comb begin
        if (length_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (length_reg > LENGTH_W'(MAX_LEN)) begin
            n_eff = CNT_W'(MAX_LEN);
        end else begin
            n_eff = CNT_W'(length_reg);
        end
        n_m1 = LVL_W'(n_eff - CNT_W'(1));
    end

    always_comb begin
        cur_idx = lvl_idx_reg[lv_reg];
        if (CNT_W'(cur_idx) >= n_eff || cur_idx < lv_reg) begin
            clamp_idx = lv_reg;
        end else begin
            clamp_idx = cur_idx;
        end
        idx_inc     = CNT_W'(clamp_idx) + CNT_W'(1);
        partner     = cmd.redo ? nidx_reg : clamp_idx;
        sym_lv      = order_reg[lv_reg];
        sym_partner = order_reg[partner];
    end

    assign status.started  = started_reg;
    assign status.more     = idx_inc < n_eff;
    assign status.top      = lv_reg == '0;
    assign status.out_busy = out_valid_reg && !m_tready;

    always_comb begin
        packed_w = '0;
        last_w   = 1'b1;
        for (int k = 0; k < MAX_LEN; k++) begin
            if (CNT_W'(k) < n_eff) begin
                packed_w[k*SYMBOL_BITS +: SYMBOL_BITS] = order_reg[k];
                if (lvl_idx_reg[k] != n_m1) begin
                    last_w = 1'b0;
                end
            end
        end
    end

    always_comb begin
        started_next   = started_reg;
        lv_next        = lv_reg;
        nidx_next      = nidx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        for (int k = 0; k < MAX_LEN; k++) begin
            order_next[k]   = order_reg[k];
            lvl_idx_next[k] = lvl_idx_reg[k];
        end
        if (cfg_wr_en && cfg_wr_index == REG_LENGTH) begin
            started_next = 1'b0;
        end
        if (cmd.load) begin
            started_next = 1'b1;
            lv_next      = n_m1;
            for (int k = 0; k < MAX_LEN; k++) begin
                lvl_idx_next[k] = LVL_W'(k);
                if (CNT_W'(k) < n_eff) begin
                    order_next[k] = symbols_reg[k*SYMBOL_BITS +: SYMBOL_BITS];
                end else begin
                    order_next[k] = '0;
                end
            end
        end
        if (cmd.undo || cmd.redo) begin
            for (int k = 0; k < MAX_LEN; k++) begin
                if (LVL_W'(k) == lv_reg) begin
                    order_next[k] = sym_partner;
                end else if (LVL_W'(k) == partner) begin
                    order_next[k] = sym_lv;
                end
            end
        end
        if (cmd.undo) begin
            nidx_next = LVL_W'(idx_inc);
        end
        if (cmd.up) begin
            lv_next = lv_reg - LVL_W'(1);
        end
        if (cmd.redo) begin
            lvl_idx_next[lv_reg] = nidx_reg;
            for (int k = 0; k < MAX_LEN; k++) begin
                if (LVL_W'(k) > lv_reg) begin
                    lvl_idx_next[k] = LVL_W'(k);
                end
            end
            lv_next = n_m1;
        end
        if (cmd.wrap) begin
            for (int k = 0; k < MAX_LEN; k++) begin
                lvl_idx_next[k] = LVL_W'(k);
            end
            lv_next = n_m1;
        end
        if (cmd.capture) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbols_reg   <= '0;
            length_reg    <= LENGTH_W'(1);
            started_reg   <= 1'b0;
            lv_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_LEN; k++) begin
                lvl_idx_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en && cfg_wr_index == REG_SYMBOLS) begin
                symbols_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_wr_index == REG_LENGTH) begin
                length_reg <= cfg_wr_data[LENGTH_W-1:0];
            end
            started_reg   <= started_next;
            lv_reg        <= lv_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < MAX_LEN; k++) begin
                lvl_idx_reg[k] <= lvl_idx_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        nidx_reg <= nidx_next;
        for (int k = 0; k < MAX_LEN; k++) begin
            order_reg[k] <= order_next[k];
        end
        if (cmd.capture) begin
            out_data_reg <= packed_w;
            out_last_reg <= last_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `SPG_ASSERT_NOW(a_level_in_range, started_reg, CNT_W'(lv_reg) < n_eff)
    `SPG_ASSERT_NEXT(a_load_marks_started, cmd.load, started_reg)
    `SPG_ASSERT_NEXT(a_capture_sets_valid, cmd.capture, out_valid_reg)

endmodule

// ===== design/spg_controller.sv =====
// Controller state machine sequencing reload, backtrack and redescend.
`include "swap_permutation_generator_unit_macros.svh"

module spg_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  restart,
    input  spg_pkg::spg_status_t  status,
    output spg_pkg::spg_cmd_t     cmd
);
    import spg_pkg::*;

    spg_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (restart || !status.started) begin
                        state_next = ST_LOAD;
                    end else begin
                        state_next = ST_UNDO;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_UNDO: begin
                cmd.undo = 1'b1;
                if (status.more) begin
                    state_next = ST_REDO;
                end else if (status.top) begin
                    state_next = ST_WRAP;
                end else begin
                    cmd.up = 1'b1;
                end
            end
            ST_REDO: begin
                cmd.redo   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_WRAP: begin
                cmd.wrap   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!status.out_busy) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SPG_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `SPG_ASSERT_NOW(a_one_major_cmd, 1'b1,
        $onehot0({cmd.load, cmd.undo, cmd.redo, cmd.wrap, cmd.capture}))
    `SPG_ASSERT_NOW(a_up_only_when_exhausted, cmd.up, cmd.undo && !status.more && !status.top)

endmodule

// ===== design/swap_permutation_generator_unit.sv =====
// Top level of the swap permutation generator: controller plus datapath.
//
//  Channel   Direction  Ports                          Beat contents
//  -------   ---------  -----------------------------  ---------------------------------
//  request   in         s_tvalid s_tready s_tdata      bit 0 restart, bits 7:1 zero
//  result    out        m_tvalid m_tready m_tdata      arrangement (64 bits)
//                       m_tlast                        last permutation of the listing
//  config    in         cfg_wr_en cfg_wr_index         index 0 symbols, index 1 length
//                       cfg_wr_data
//
// A request beat that reloads the string goes through the load step and then the
// loading of the output register. A request for the next ordering goes through
// the undo state, which undoes one level's swap per cycle while it backtracks up
// the level stack, then the next swap and redescent (or the wrap once level zero
// is exhausted), then the loading of the output register. Reset is synchronous and
// active low; it resets the configuration, the level stack and the control state,
// and the first request after it always reloads the string. The output register
// lets the next request be taken while a result beat waits; a stalled result holds
// the machine only when the following result is ready to be stored.
module swap_permutation_generator_unit #(
    parameter int MAX_LEN     = spg_pkg::DEF_MAX_LEN,
    parameter int SYMBOL_BITS = spg_pkg::DEF_SYMBOL_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write port.
    input  logic                           cfg_wr_en,
    input  logic [spg_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [spg_pkg::SYMBOLS_W-1:0]  cfg_wr_data,
    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [spg_pkg::IN_DATA_W-1:0]  s_tdata,   // bit 0: restart; rest zero fill
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [spg_pkg::SYMBOLS_W-1:0]  m_tdata,   // bits 63:0: arrangement
    output logic                           m_tlast
);
    import spg_pkg::*;

    spg_cmd_t    cmd;
    spg_status_t status;

    // The controller decides the sequence of steps; the restart flag is only
    // looked at in the cycle the request beat is accepted.
    spg_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .restart  (s_tdata[0]),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the working string, the per-level swap indices and the
    // result register, and carries out the commands that the controller issues.
    spg_datapath #(
        .MAX_LEN     (MAX_LEN),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the swap permutation generator top level.
module testbench;

    import spg_pkg::*;

    localparam int MAX_LEN      = DEF_MAX_LEN;
    localparam int SYMBOL_BITS  = DEF_SYMBOL_BITS;
    localparam int HALF_PERIOD  = 6;
    // Time allowed after the last due ordering arrives before the block is taken to be idle.
    localparam int SETTLE_CYCLES = 2 * MAX_LEN + 8;
    // Length of the long receiver hold-off used to fill the block up.
    localparam int HOLD_CYCLES   = 250;
    // Cycle limit for the whole run; a run that reaches it has hung.
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_ITEMS  = 1150;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_wr_index;
    logic [SYMBOLS_W-1:0]   cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;    // bit 0: restart; bits 7:1 zero
    logic                   m_tvalid;
    logic                   m_tready;
    logic [SYMBOLS_W-1:0]   m_tdata;    // bits 63:0: arrangement
    logic                   m_tlast;

    // One expected result beat: the ordering and its final-ordering flag.
    typedef struct {
        logic [SYMBOLS_W-1:0] arrangement;
        logic                 last;
    } perm_beat_t;

    // Shadow of the generator: its own copy of the registers, the working string and
    // the per-level swap indices, plus the queue of orderings still to arrive.
    class perm_scoreboard;
        logic [SYMBOLS_W-1:0]   symbols_reg;
        logic [LENGTH_W-1:0]    length_reg;
        logic [SYMBOL_BITS-1:0] order [MAX_LEN];
        int                     swap_index [MAX_LEN];
        bit                     started;
        perm_beat_t             orderings_due [$];
        int unsigned            requests;
        int unsigned            results;
        int unsigned            finals;
        int unsigned            mismatches;

        function new();
            symbols_reg = '0;
            length_reg  = 4'd1;
            started     = 1'b0;
            requests    = 0;
            results     = 0;
            finals      = 0;
            mismatches  = 0;
            for (int k = 0; k < MAX_LEN; k++) begin
                order[k]      = '0;
                swap_index[k] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SYMBOLS_W-1:0] value);
            if (idx == REG_SYMBOLS) begin
                symbols_reg = value;
            end else begin
                // A new length forces the next request to reload the string.
                length_reg = value[LENGTH_W-1:0];
                started    = 1'b0;
            end
        endfunction

        function int active_len();
            int n;
            n = int'(length_reg);
            if (n < 1) n = 1;
            if (n > MAX_LEN) n = MAX_LEN;
            return n;
        endfunction

        function void swap_pos(int a, int b);
            logic [SYMBOL_BITS-1:0] t;
            t        = order[a];
            order[a] = order[b];
            order[b] = t;
        endfunction

        function void descend(int from, int n);
            for (int lv = from; lv < n; lv++) swap_index[lv] = lv;
        endfunction

        // Undo swaps from the deepest level upwards until a level has another partner,
        // then apply that swap and reset every level below it.  When level zero is
        // exhausted too, every swap has been undone and the listing starts again.
        function void advance(int n);
            int idx;
            for (int lv = n - 1; lv >= 0; lv--) begin
                idx = swap_index[lv];
                if (idx >= n || idx < lv) idx = lv;
                swap_pos(lv, idx);
                idx++;
                if (idx < n) begin
                    swap_index[lv] = idx;
                    swap_pos(lv, idx);
                    descend(lv + 1, n);
                    return;
                end
            end
            descend(0, n);
        endfunction

        function void note_request(bit restart);
            int         n;
            perm_beat_t beat;
            n = active_len();
            requests++;
            if (restart || !started) begin
                for (int k = 0; k < MAX_LEN; k++)
                    order[k] = (k < n) ? symbols_reg[k*SYMBOL_BITS +: SYMBOL_BITS] : '0;
                descend(0, n);
                started = 1'b1;
            end else begin
                advance(n);
            end
            beat.arrangement = '0;
            beat.last        = 1'b1;
            for (int k = 0; k < n; k++) begin
                beat.arrangement[k*SYMBOL_BITS +: SYMBOL_BITS] = order[k];
                if (swap_index[k] != n - 1) beat.last = 1'b0;
            end
            orderings_due.push_back(beat);
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: %s", msg);
        endfunction

        function void check_result(logic [SYMBOLS_W-1:0] arrangement, logic last);
            perm_beat_t due;
            results++;
            if (last === 1'b1) finals++;
            if (orderings_due.size() == 0) begin
                report($sformatf("result beat %0d arrived with none due: %h last %b",
                                 results, arrangement, last));
                return;
            end
            due = orderings_due.pop_front();
            if (arrangement !== due.arrangement)
                report($sformatf("beat %0d arrangement: expected %h, got %h",
                                 results, due.arrangement, arrangement));
            if (last !== due.last)
                report($sformatf("beat %0d last: expected %b, got %b",
                                 results, due.last, last));
        endfunction
    endclass

    perm_scoreboard sb = new();

    // Idling controls, set per phase by the stimulus process.
    int  tx_idle_pct  = 0;
    int  rx_stall_pct = 0;
    bit  start_hold   = 1'b0;
    int  held_cycles  = 0;
    int  cfg_writes   = 0;
    int  cycles       = 0;

    swap_permutation_generator_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // Run guard: a hang anywhere ends the run as a failure.
    initial begin
        while (cycles < LIMIT_CYCLES) @(posedge aclk) cycles++;
        $display("Timeout after %0d cycles with %0d orderings still due.",
                 cycles, sb.orderings_due.size());
        $display("** swap_permutation_generator_unit: FAILED **");
        $finish;
    end

    // Result side.  Values read just after the edge are the ones the block saw at that
    // edge, so a beat is taken exactly when both tvalid and tready were high.  Ready is
    // then redrawn for the next edge, or held low while a long hold-off is running.
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1) sb.check_result(m_tdata, m_tlast);
            if (start_hold) begin
                hold_left  = HOLD_CYCLES;
                start_hold = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                held_cycles++;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    // Register writes are only issued with the block idle.  Enable is dropped for a
    // cycle between writes so that it never gets two assignments in one step.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SYMBOLS_W-1:0] value);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
        cfg_writes++;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one request beat and waits for the handshake.  Valid stays high on return,
    // so a back-to-back beat follows without a gap.
    task automatic send_request(bit restart);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-1){1'b0}}, restart};
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        sb.note_request(restart);
    endtask

    // A burst of requests: the first with the given restart bit, the rest restarting at
    // the given rate, with random sender gaps between beats.  Valid is left low for one
    // cycle at the end, so that a following burst drives it in a later step.
    task automatic request_burst(int count, bit restart_first, int restart_pct);
        int gap;
        for (int i = 0; i < count; i++) begin
            if (i == 0) send_request(restart_first);
            else send_request($urandom_range(0, 99) < restart_pct);
            gap = 0;
            while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) gap++;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // Waits until every due ordering has arrived, then lets the block settle.
    task automatic wait_drained();
        while (sb.orderings_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [SYMBOLS_W-1:0] pick_symbols();
        logic [SYMBOLS_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = '0;
            1: s = '1;
            2, 3: begin
                // Only two distinct symbols, so repeated orderings are common.
                for (int k = 0; k < MAX_LEN; k++)
                    s[k*SYMBOL_BITS +: SYMBOL_BITS] = $urandom_range(0, 1) ? 8'h5A : 8'hA5;
            end
            default: s = {$urandom, $urandom};
        endcase
        return s;
    endfunction

    // Mostly short strings, so that the listing wraps often; now and then the longest
    // string, a length of zero, or a length above the maximum.
    function automatic logic [SYMBOLS_W-1:0] pick_length();
        logic [SYMBOLS_W-1:0] v;
        int                   r;
        v = {$urandom, $urandom};
        r = $urandom_range(0, 99);
        if (r < 8)       v[LENGTH_W-1:0] = 4'd0;
        else if (r < 60) v[LENGTH_W-1:0] = LENGTH_W'($urandom_range(1, 4));
        else if (r < 85) v[LENGTH_W-1:0] = LENGTH_W'($urandom_range(5, 6));
        else if (r < 95) v[LENGTH_W-1:0] = LENGTH_W'($urandom_range(7, 8));
        else             v[LENGTH_W-1:0] = LENGTH_W'($urandom_range(9, 15));
        return v;
    endfunction

    initial begin
        int phase;
        int mode;

        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_index <= REG_SYMBOLS;
        cfg_wr_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, no idling on either side.
        // The first request after reset reloads even with restart low; with the reset
        // length of one the listing has a single ordering and wraps onto itself.
        request_burst(2, 1'b0, 0);
        wait_drained();

        // Three symbols with junk above them: six orderings, the wrap, then a restart
        // partway through the listing.
        cfg_write(REG_SYMBOLS, 64'hDEAD_BEEF_0033_2211);
        cfg_write(REG_LENGTH, 64'd3);
        request_burst(8, 1'b0, 0);
        request_burst(1, 1'b1, 0);
        wait_drained();

        // New symbols alone must not disturb the listing until the next reload.
        cfg_write(REG_SYMBOLS, 64'h0000_0000_0077_6655);
        request_burst(2, 1'b0, 0);
        request_burst(1, 1'b1, 0);
        wait_drained();

        // A length of zero behaves as one.
        cfg_write(REG_LENGTH, 64'd0);
        request_burst(2, 1'b0, 0);
        wait_drained();

        // All-ones symbols with an oversized length, which saturates to the maximum.
        cfg_write(REG_SYMBOLS, '1);
        cfg_write(REG_LENGTH, 64'd15);
        request_burst(2, 1'b0, 0);
        request_burst(1, 1'b1, 0);
        wait_drained();

        // Repeated symbols give repeated orderings.
        cfg_write(REG_SYMBOLS, 64'h0000_0000_000B_0A0A);
        cfg_write(REG_LENGTH, 64'd3);
        request_burst(4, 1'b0, 0);
        wait_drained();

        // Random part.  Each phase may change the registers, then walks the listing with
        // the odd restart, under one of four idling patterns in turn.
        phase = 0;
        while (sb.requests < 23 + RANDOM_ITEMS) begin
            mode = phase % 4;
            case (mode)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
                default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
            endcase
            if ($urandom_range(0, 99) < 75) cfg_write(REG_SYMBOLS, pick_symbols());
            if ($urandom_range(0, 99) < 70) cfg_write(REG_LENGTH, pick_length());
            if (phase == 5) begin
                // Hold the result side off for a long stretch while requests keep
                // coming, so that the output register fills and the input stalls.
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
                start_hold   = 1'b1;
            end
            request_burst($urandom_range(20, 80), $urandom_range(0, 1), 4);
            wait_drained();
            phase++;
        end

        $display("Covered %0d requests and %0d result beats (%0d final orderings), %0d register",
                 sb.requests, sb.results, sb.finals, cfg_writes);
        $display("writes over %0d random phases, with the result side held off for %0d cycles.",
                 phase, held_cycles);
        if (sb.orderings_due.size() != 0)
            $display("%0d orderings were still due at the end.", sb.orderings_due.size());
        if (sb.mismatches == 0 && sb.orderings_due.size() == 0) begin
            $display("** swap_permutation_generator_unit: PASSED **");
        end else begin
            $display("%0d mismatches in total.", sb.mismatches);
            $display("** swap_permutation_generator_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== swap_permutation_generator_unit.f =====
+incdir+design
design/spg_pkg.sv
design/spg_datapath.sv
design/spg_controller.sv
design/swap_permutation_generator_unit.sv
tb/testbench.sv
